### hw/rtl/ansi_terminal_command_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the terminal command encoder
// Immediate-implication and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ANSI_TERMINAL_COMMAND_ENCODER_ASSERT_SVH
`define ANSI_TERMINAL_COMMAND_ENCODER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define ATE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ATE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ate_pkg.sv
// ----------------------------------------------------------------------------
// ate_pkg
// Command codes, byte constants, template tokens and converter handshake types.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int SECOND_W = 8;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 4;
  localparam int NARROW_W = 9;    // widest small field: second_value + 10
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W    = 4 * BCD_DIGITS;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_CRLF   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CLS    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_UP     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DOWN   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_MOVETO = 4'd8;
  localparam logic [KIND_W-1:0] KIND_COLOR  = 4'd9;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 4'd10;

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h43;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h44;
  localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;

  // template token operations
  localparam logic [1:0] OP_END = 2'd0;
  localparam logic [1:0] OP_LIT = 2'd1;
  localparam logic [1:0] OP_RAW = 2'd2;   // low byte of first_value
  localparam logic [1:0] OP_NUM = 2'd3;   // decimal of a source field

  // number sources
  localparam logic [1:0] SRC_FIRST = 2'd0;  // signed first_value
  localparam logic [1:0] SRC_LO    = 2'd1;  // low byte of first_value
  localparam logic [1:0] SRC_SV    = 2'd2;  // second_value
  localparam logic [1:0] SRC_SV10  = 2'd3;  // second_value + 10

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] lit;
    logic [1:0]        src;
  } tok_t;

  typedef struct packed {
    logic start;
    logic narrow;
    logic pop;
  } bcd_ctl_t;

  typedef struct packed {
    logic       done;
    logic       one_left;
    logic [3:0] msd;
  } bcd_stat_t;

  localparam tok_t TOK_NONE = '{op: OP_END, lit: 8'h00, src: SRC_FIRST};

  function automatic tok_t lit_tok(input logic [BYTE_W-1:0] b);
    tok_t t;
    t = '{op: OP_LIT, lit: b, src: SRC_FIRST};
    return t;
  endfunction

  function automatic tok_t num_tok(input logic [1:0] s);
    tok_t t;
    t = '{op: OP_NUM, lit: 8'h00, src: s};
    return t;
  endfunction

  // Byte template of each command, one token per index.
  function automatic tok_t tmpl(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
    tok_t t;
    logic [BYTE_W-1:0] dir;
    t = TOK_NONE;
    unique case (kind)
      KIND_UP:   dir = CH_UP;
      KIND_DOWN: dir = CH_DOWN;
      KIND_LEFT: dir = CH_LEFT;
      default:   dir = CH_RIGHT;
    endcase
    unique case (kind)
      KIND_CHAR: begin
        if (idx == 4'd0) t = '{op: OP_RAW, lit: 8'h00, src: SRC_FIRST};
      end
      KIND_CRLF: begin
        if (idx == 4'd0) t = lit_tok(CH_CR);
        else if (idx == 4'd1) t = lit_tok(CH_LF);
      end
      KIND_NUMBER: begin
        if (idx == 4'd0) t = num_tok(SRC_FIRST);
      end
      KIND_CLS: begin
        unique case (idx)
          4'd0:    t = lit_tok(CH_ESC);
          4'd1:    t = lit_tok(CH_LBRK);
          4'd2:    t = lit_tok(CH_TWO);
          4'd3:    t = lit_tok(CH_J);
          default: t = TOK_NONE;
        endcase
      end
      KIND_UP, KIND_DOWN, KIND_LEFT, KIND_RIGHT: begin
        unique case (idx)
          4'd0:    t = lit_tok(CH_ESC);
          4'd1:    t = lit_tok(CH_LBRK);
          4'd2:    t = num_tok(SRC_LO);
          4'd3:    t = lit_tok(dir);
          default: t = TOK_NONE;
        endcase
      end
      KIND_MOVETO: begin
        unique case (idx)
          4'd0:    t = lit_tok(CH_ESC);
          4'd1:    t = lit_tok(CH_LBRK);
          4'd2:    t = num_tok(SRC_SV);
          4'd3:    t = lit_tok(CH_SEMI);
          4'd4:    t = num_tok(SRC_LO);
          4'd5:    t = lit_tok(CH_H);
          default: t = TOK_NONE;
        endcase
      end
      KIND_COLOR: begin
        unique case (idx)
          4'd0:    t = lit_tok(CH_ESC);
          4'd1:    t = lit_tok(CH_LBRK);
          4'd2:    t = lit_tok(CH_ZERO);
          4'd3:    t = lit_tok(CH_SEMI);
          4'd4:    t = num_tok(SRC_LO);
          4'd5:    t = lit_tok(CH_SEMI);
          4'd6:    t = num_tok(SRC_SV10);
          4'd7:    t = lit_tok(CH_M);
          default: t = TOK_NONE;
        endcase
      end
      KIND_ERASE: begin
        unique case (idx)
          4'd0:    t = lit_tok(CH_ESC);
          4'd1:    t = lit_tok(CH_LBRK);
          4'd2:    t = lit_tok(CH_K);
          default: t = TOK_NONE;
        endcase
      end
      default: t = TOK_NONE;
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/ate_ifs.sv
// ----------------------------------------------------------------------------
// ate_cmd_if / ate_byte_if
// Valid/ready channels for commands in and terminal bytes out.
// ----------------------------------------------------------------------------
interface ate_cmd_if import ate_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  first_value;
  logic [SECOND_W-1:0]        second_value;

  modport source (output valid, output kind, output first_value, output second_value,
                  input ready);
  modport sink   (input valid, input kind, input first_value, input second_value,
                  output ready);
endinterface

interface ate_byte_if import ate_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### hw/rtl/ate_bcd.sv
// ----------------------------------------------------------------------------
// ate_bcd
// Bit-serial binary to BCD (shift and add-3), leading-zero trim, then
// hands out digits most significant first, one per pop.
// ----------------------------------------------------------------------------
module ate_bcd import ate_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  bcd_ctl_t           ctl,
  input  logic [VALUE_W-1:0] mag,
  output bcd_stat_t          st
);

  localparam int CNT_W = $clog2(VALUE_W + 1);
  localparam int DIG_W = $clog2(BCD_DIGITS + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DAB  = 2'd1;
  localparam logic [1:0] P_TRIM = 2'd2;
  localparam logic [1:0] P_DONE = 2'd3;

  logic [1:0]         phase;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic [CNT_W-1:0]   cnt;
  logic [DIG_W-1:0]   ndig;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (ctl.start) begin
            bcd <= '0;
            if (ctl.narrow) begin
              bin <= {mag[NARROW_W-1:0], {(VALUE_W-NARROW_W){1'b0}}};
              cnt <= CNT_W'(NARROW_W);
            end else begin
              bin <= mag;
              cnt <= CNT_W'(VALUE_W);
            end
            phase <= P_DAB;
          end
        end
        P_DAB: begin
          bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            ndig  <= DIG_W'(BCD_DIGITS);
            phase <= P_TRIM;
          end
        end
        P_TRIM: begin
          // drop leading zeros, keep at least one digit
          if (bcd[BCD_W-1 -: 4] == 4'd0 && ndig > DIG_W'(1)) begin
            bcd  <= {bcd[BCD_W-5:0], 4'd0};
            ndig <= ndig - 1'b1;
          end else begin
            phase <= P_DONE;
          end
        end
        default: begin
          if (ctl.pop) begin
            bcd  <= {bcd[BCD_W-5:0], 4'd0};
            ndig <= ndig - 1'b1;
            if (ndig == DIG_W'(1)) phase <= P_IDLE;
          end
        end
      endcase
    end
  end

  assign st.done     = (phase == P_DONE);
  assign st.one_left = (ndig == DIG_W'(1));
  assign st.msd      = bcd[BCD_W-1 -: 4];

endmodule

### hw/rtl/ate_txreg.sv
// ----------------------------------------------------------------------------
// ate_txreg
// Output register between the sequencer and the byte channel.
// ----------------------------------------------------------------------------
module ate_txreg import ate_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [BYTE_W-1:0] din,
  input  logic              din_last,
  output logic              space,
  ate_byte_if.source        tx
);

  logic              full;
  logic [BYTE_W-1:0] data;
  logic              data_last;

  assign space = !full || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (tx.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data      <= din;
      data_last <= din_last;
    end
  end

  assign tx.valid    = full;
  assign tx.out_byte = data;
  assign tx.last     = data_last;

endmodule

### hw/rtl/ansi_terminal_command_encoder.sv
// ----------------------------------------------------------------------------
// ansi_terminal_command_encoder
// Turns terminal commands into VT100/ANSI byte runs, one byte per item.
//
//   channel  dir  payload                           accepted when
//   cmd      in   kind, first_value, second_value   valid && ready
//   tx       out  out_byte, last                    valid && ready
//
// A command is taken only while the sequencer is idle; kinds 11..15 give no
// bytes. Literal bytes go out one at a time. A number is started, converted to
// BCD one bit at a time (32 bits, 9 for the narrow fields), trimmed of leading
// zeros and handed over, then sent one digit at a time after a '-' if negative.
// Backpressure on tx stalls the sequencer; one byte waits in the output register.
// Reset (rst, synchronous) returns to idle with the output register empty.
// ----------------------------------------------------------------------------
`include "ansi_terminal_command_encoder_assert.svh"

module ansi_terminal_command_encoder import ate_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ate_cmd_if.sink    cmd,
  ate_byte_if.source tx
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TOK  = 3'd1;
  localparam logic [2:0] S_CONV = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;

  logic [2:0]          state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic                neg, neg_next;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  first;
  logic [SECOND_W-1:0] second;

  tok_t               tok;
  logic               nxt_end;
  logic               kind_ok;
  logic [VALUE_W-1:0] mag;
  logic [NARROW_W-1:0] sv10;
  bcd_ctl_t           bcd_ctl;
  bcd_stat_t          bcd_st;
  logic               space;
  logic               load;
  logic [BYTE_W-1:0]  load_byte;
  logic               load_last;

  assign cmd.ready = (state == S_IDLE);
  assign kind_ok   = (tmpl(cmd.kind, '0).op != OP_END);

  assign tok     = tmpl(kind, idx);
  assign nxt_end = (tmpl(kind, idx + 1'b1).op == OP_END);
  assign sv10    = {1'b0, second} + NARROW_W'(10);

  always_comb begin
    unique case (tok.src)
      SRC_FIRST: mag = first[VALUE_W-1] ? (~first + 1'b1) : first;
      SRC_LO:    mag = {{(VALUE_W-BYTE_W){1'b0}}, first[BYTE_W-1:0]};
      SRC_SV:    mag = {{(VALUE_W-SECOND_W){1'b0}}, second};
      default:   mag = {{(VALUE_W-NARROW_W){1'b0}}, sv10};
    endcase
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    neg_next       = neg;
    load           = 1'b0;
    load_byte      = tok.lit;
    load_last      = 1'b0;
    bcd_ctl.start  = 1'b0;
    bcd_ctl.narrow = (tok.src != SRC_FIRST);
    bcd_ctl.pop    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid && kind_ok) begin
          state_next = S_TOK;
          idx_next   = '0;
        end
      end
      S_TOK: begin
        unique case (tok.op)
          OP_LIT, OP_RAW: begin
            load_byte = (tok.op == OP_RAW) ? first[BYTE_W-1:0] : tok.lit;
            load_last = nxt_end;
            if (space) begin
              load     = 1'b1;
              idx_next = idx + 1'b1;
              if (nxt_end) state_next = S_IDLE;
            end
          end
          OP_NUM: begin
            bcd_ctl.start = 1'b1;
            neg_next      = (tok.src == SRC_FIRST) && first[VALUE_W-1];
            state_next    = S_CONV;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CONV: begin
        if (bcd_st.done) state_next = neg ? S_SIGN : S_DIG;
      end
      S_SIGN: begin
        load_byte = CH_MINUS;
        if (space) begin
          load       = 1'b1;
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        load_byte = CH_ZERO + {4'd0, bcd_st.msd};
        load_last = bcd_st.one_left && nxt_end;
        if (space) begin
          load        = 1'b1;
          bcd_ctl.pop = 1'b1;
          if (bcd_st.one_left) begin
            idx_next   = idx + 1'b1;
            state_next = nxt_end ? S_IDLE : S_TOK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      neg   <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      kind   <= cmd.kind;
      first  <= cmd.first_value;
      second <= cmd.second_value;
    end
  end

  ate_bcd u_bcd (
    .clk (clk),
    .rst (rst),
    .ctl (bcd_ctl),
    .mag (mag),
    .st  (bcd_st)
  );

  ate_txreg u_txreg (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .din      (load_byte),
    .din_last (load_last),
    .space    (space),
    .tx       (tx)
  );

  `ATE_ASSERT_NOW(a_load_space, load, space, "byte loaded into a full output register")
  `ATE_ASSERT_NOW(a_pop_done, bcd_ctl.pop, bcd_st.done, "digit taken before conversion done")
  `ATE_ASSERT_NOW(a_start_tok, bcd_ctl.start, state == S_TOK, "conversion started outside token step")
  `ATE_ASSERT_NEXT(a_last_idle, load && load_last, state == S_IDLE, "run ended but sequencer busy")
  `ATE_ASSERT_NEXT(a_cmd_start, cmd.valid && cmd.ready && kind_ok, state == S_TOK,
                   "accepted command did not start")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Terminal command encoder testbench
// Sends terminal commands over the cmd channel and checks every byte that
// comes out on tx against its expected byte run. A short table of directed
// commands comes first, then random commands. Both handshake sides idle at
// random, and the receiver once holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module testbench import ate_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 120;     // longest number conversion plus margin
  localparam int RANDOM_CMDS   = 106;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 120;     // bytes seen before the long hold

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd11;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } tx_beat_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  first_value;
    logic [SECOND_W-1:0] second_value;
    bit                  typed;   // text holds the exact byte run
    string               text;
  } cmd_row_t;

  localparam int NUM_ROWS = 24;

  cmd_row_t directed_rows [NUM_ROWS] = '{
    '{KIND_CHAR,   32'h0000_0041, 8'h00, 1'b1, "A"},
    '{KIND_CHAR,   32'hFFFF_FF7A, 8'h00, 1'b1, "z"},
    '{KIND_CHAR,   32'h0000_0000, 8'h00, 1'b0, ""},
    '{KIND_CHAR,   32'h0000_00FF, 8'hFF, 1'b0, ""},
    '{KIND_CRLF,   32'h0000_0000, 8'h00, 1'b1, "\015\012"},
    '{KIND_NUMBER, 32'h0000_0000, 8'h00, 1'b1, "0"},
    '{KIND_NUMBER, 32'h7FFF_FFFF, 8'h00, 1'b1, "2147483647"},
    '{KIND_NUMBER, 32'h8000_0000, 8'h00, 1'b1, "-2147483648"},
    '{KIND_NUMBER, 32'hFFFF_FFFF, 8'hFF, 1'b1, "-1"},
    '{KIND_NUMBER, 32'd1000000000, 8'h5A, 1'b0, ""},
    '{KIND_NUMBER, 32'hFFFF_FFF6, 8'h00, 1'b0, ""},
    '{KIND_CLS,    32'h0000_0000, 8'h00, 1'b1, "\033[2J"},
    '{KIND_UP,     32'h0000_0000, 8'h00, 1'b1, "\033[0A"},
    '{KIND_DOWN,   32'h0000_00FF, 8'h00, 1'b1, "\033[255B"},
    '{KIND_LEFT,   32'h1234_5605, 8'h00, 1'b1, "\033[5D"},
    '{KIND_RIGHT,  32'd100,       8'h00, 1'b0, ""},
    '{KIND_MOVETO, 32'h0000_00FF, 8'h00, 1'b1, "\033[0;255H"},
    '{KIND_MOVETO, 32'hFFFF_FF00, 8'hFF, 1'b1, "\033[255;0H"},
    '{KIND_COLOR,  32'h0000_0007, 8'h00, 1'b1, "\033[0;7;10m"},
    '{KIND_COLOR,  32'h0000_00FF, 8'hFF, 1'b1, "\033[0;255;265m"},
    '{KIND_COLOR,  32'h0000_0000, 8'd246, 1'b0, ""},
    '{KIND_ERASE,  32'h0000_0000, 8'h00, 1'b1, "\033[K"},
    '{KIND_UNUSED_LO, 32'hFFFF_FFFF, 8'hFF, 1'b1, ""},
    '{KIND_UNUSED_HI, 32'h0000_0000, 8'h00, 1'b1, ""}
  };

  logic clk;
  logic rst;

  ate_cmd_if  cmd_ch ();
  ate_byte_if tx_ch ();

  ansi_terminal_command_encoder dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .tx  (tx_ch.source)
  );

  tx_beat_t          expected_bytes[$];
  logic [BYTE_W-1:0] run_bytes[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  int                cmd_calm = 0;
  int                rx_calm = 0;
  int                rx_gap = 0;
  int                hold_left = 0;
  int                beats_seen = 0;
  bit                long_hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and calm stretches with none at all.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_decimal(input logic [31:0] mag);
    logic [BYTE_W-1:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + BYTE_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digits[i]) run_bytes.push_back(digits[i]);
  endfunction

  function automatic void queue_run();
    tx_beat_t b;
    foreach (run_bytes[i]) begin
      b.data = run_bytes[i];
      b.last = (i == run_bytes.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  // Byte run that one command turns into.
  function automatic void predict_run(input logic [KIND_W-1:0] kind,
                                      input logic [VALUE_W-1:0] fv,
                                      input logic [SECOND_W-1:0] sv);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] dir;
    lo = fv[7:0];
    run_bytes.delete();
    case (kind)
      KIND_UP:   dir = CH_UP;
      KIND_DOWN: dir = CH_DOWN;
      KIND_LEFT: dir = CH_LEFT;
      default:   dir = CH_RIGHT;
    endcase
    case (kind)
      KIND_CHAR: run_bytes.push_back(lo);
      KIND_CRLF: begin
        run_bytes.push_back(CH_CR);
        run_bytes.push_back(CH_LF);
      end
      KIND_NUMBER: begin
        if (fv[31]) begin
          run_bytes.push_back(CH_MINUS);
          add_decimal(~fv + 32'd1);
        end else begin
          add_decimal(fv);
        end
      end
      KIND_CLS: begin
        run_bytes.push_back(CH_ESC);
        run_bytes.push_back(CH_LBRK);
        run_bytes.push_back(CH_TWO);
        run_bytes.push_back(CH_J);
      end
      KIND_UP, KIND_DOWN, KIND_LEFT, KIND_RIGHT: begin
        run_bytes.push_back(CH_ESC);
        run_bytes.push_back(CH_LBRK);
        add_decimal({24'd0, lo});
        run_bytes.push_back(dir);
      end
      KIND_MOVETO: begin
        run_bytes.push_back(CH_ESC);
        run_bytes.push_back(CH_LBRK);
        add_decimal({24'd0, sv});
        run_bytes.push_back(CH_SEMI);
        add_decimal({24'd0, lo});
        run_bytes.push_back(CH_H);
      end
      KIND_COLOR: begin
        run_bytes.push_back(CH_ESC);
        run_bytes.push_back(CH_LBRK);
        run_bytes.push_back(CH_ZERO);
        run_bytes.push_back(CH_SEMI);
        add_decimal({24'd0, lo});
        run_bytes.push_back(CH_SEMI);
        add_decimal({24'd0, sv} + 32'd10);
        run_bytes.push_back(CH_M);
      end
      KIND_ERASE: begin
        run_bytes.push_back(CH_ESC);
        run_bytes.push_back(CH_LBRK);
        run_bytes.push_back(CH_K);
      end
      default: ;  // unused kinds give no bytes
    endcase
    queue_run();
  endfunction

  function automatic void queue_text(input string text);
    run_bytes.delete();
    for (int i = 0; i < text.len(); i++) run_bytes.push_back(text[i]);
    queue_run();
  endfunction

  // Offer one command; expectations are queued once it is taken.
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] fv,
                          input logic [SECOND_W-1:0] sv, input bit typed,
                          input string text);
    int gap;
    gap = pick_gap(cmd_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= kind;
    cmd_ch.first_value  <= fv;
    cmd_ch.second_value <= sv;
    do @(posedge clk); while (!cmd_ch.ready);
    if (typed) queue_text(text);
    else predict_run(kind, fv, sv);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return $urandom_range(0, 255);
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      4: return -$urandom_range(1, 100000);
      default: return {24'($urandom), 8'($urandom_range(0, 255))};
    endcase
  endfunction

  // Cycle limit.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Byte receiver and checker.
  initial begin
    tx_beat_t want;
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tx_ch.valid && tx_ch.ready) begin
        beats_seen++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, tx_ch.out_byte, tx_ch.last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (tx_ch.out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data,
                     tx_ch.out_byte);
            mismatches++;
          end
          if (tx_ch.last !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, tx_ch.last);
            mismatches++;
          end
        end
        rx_gap = pick_gap(rx_calm);
        if (!long_hold_done && beats_seen >= HOLD_AFTER) begin
          long_hold_done = 1;
          hold_left = LONG_HOLD;
        end
      end
      if (rst) begin
        tx_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        tx_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        tx_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        tx_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [KIND_W-1:0]   kind;
    logic [SECOND_W-1:0] sv;
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.kind         <= KIND_CHAR;
    cmd_ch.first_value  <= '0;
    cmd_ch.second_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].kind, directed_rows[i].first_value,
               directed_rows[i].second_value, directed_rows[i].typed, directed_rows[i].text);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if ($urandom_range(0, 99) < 6)
        kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else kind = KIND_W'($urandom_range(KIND_CHAR, KIND_ERASE));
      if ($urandom_range(0, 9) == 0) sv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else sv = SECOND_W'($urandom_range(0, 255));
      send_cmd(kind, random_value(), sv, 1'b0, "");
    end
    cmd_ch.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
